@@ hdl/aes_cbc_pkg.sv @@
// AES-CBC encrypt package: sequencer state type, register indexes, S-box and
// round helper functions. No dependencies.
package aes_cbc_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_RUN,
        ST_OUT
    } t_state;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY0     = 3'd1;
    localparam logic [2:0] REG_KEY1     = 3'd2;
    localparam logic [2:0] REG_KEY2     = 3'd3;
    localparam logic [2:0] REG_KEY3     = 3'd4;
    localparam logic [2:0] REG_IV_HI    = 3'd5;
    localparam logic [2:0] REG_IV_LO    = 3'd6;

    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;
    localparam logic [1:0] MODE_SAT = 2'd3;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // byte k of the state sits at bits [127-8k -: 8]
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] all;
        logic [127:0] r;
        for (int k = 0; k < 16; k++) b[k] = s[127 - 8 * k -: 8];
        for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++)
                t[4 * c + q] = sbox(b[4 * ((c + q) % 4) + q]);
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                b[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
                b[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
                b[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
                b[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
            end
        end else begin
            for (int k = 0; k < 16; k++) b[k] = t[k];
        end
        for (int k = 0; k < 16; k++) r[127 - 8 * k -: 8] = b[k];
        return r;
    endfunction

endpackage

@@ hdl/aes_cbc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module aes_cbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/aes_cbc_encrypt_unit.sv @@
// AES-CBC encrypt top level: key expansion sequencer, shared round unit,
// chain register. Depends on aes_cbc_pkg and aes_cbc_ram.
// Key schedule: one word per cycle; busy after a key write until the schedule is complete.
// Each block: four key-word reads and one round step per round, Nr+1 rounds from request
// to result; the next request is taken only after the result leaves, back in idle.
// Synchronous active-low reset; reset expands the all-zero AES-128 key.
module aes_cbc_encrypt_unit
    import aes_cbc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // block_hi, block_lo
    input  logic         s_axis_tuser,   // restart_chain
    input  logic         s_axis_tlast,   // last_block
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // cipher_hi, cipher_lo
    output logic         m_axis_tlast,   // last_out
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    t_state r_state, n_state;
    logic [1:0]   r_mode;
    logic [255:0] r_key;
    logic [127:0] r_iv, r_chain, r_st;
    logic         r_last;
    logic [5:0]   r_widx;          // schedule word being produced
    logic [31:0]  r_w [8];         // sliding window of the last Nk words
    logic [7:0]   r_rcon;
    logic [2:0]   r_kc;            // i mod Nk
    logic [3:0]   r_rnd;
    logic [1:0]   r_wc;            // word counter while loading round key
    logic [95:0]  r_rk;
    logic         r_kstart;

    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   total;
    logic [31:0]  t_word, new_word, ram_rd;
    logic [5:0]   raddr;
    logic         we;

    assign nk = (r_mode == MODE_128) ? 4'd4 : (r_mode == MODE_192) ? 4'd6 : 4'd8;
    assign nr = nk + 4'd6;
    assign total = {nr, 2'b00} + 6'd4;

    // new schedule word from the window; r_w[nk-1] is w[i-1], r_w[0] is w[i-nk]
    always_comb begin
        t_word = r_w[nk[2:0] - 3'd1];
        if (nk == 4'd8) t_word = r_w[7];
        if (r_kc == 3'd0)
            t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {r_rcon, 24'd0};
        else if (nk == 4'd8 && r_kc == 3'd4)
            t_word = sub_word(t_word);
        new_word = r_w[0] ^ t_word;
    end

    assign we = (r_state == ST_KEY);

    // read address: word 4*round + word counter
    assign raddr = {r_rnd, 2'b00} + {4'd0, r_wc};

    aes_cbc_ram #(.WIDTH(32), .DEPTH(64)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_widx),
        .i_wdata(r_widx < {2'b00, nk} ? r_w[r_widx[2:0]] : new_word),
        .i_raddr(raddr),
        .o_rdata(ram_rd)
    );

    // round sub-phase: r_wc 0..3 issues reads, then r_apply applies the round
    logic r_apply;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (r_kstart && !i_cfg_we) n_state = ST_KEY;
                     else if (s_axis_tready && s_axis_tvalid) n_state = ST_RUN;
            ST_KEY:  if (r_widx == total - 6'd1) n_state = ST_IDLE;
            ST_RUN:  if (r_apply && r_rnd == nr) n_state = ST_OUT;
            ST_OUT:  if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE) && !r_kstart && !i_cfg_we;
        m_axis_tvalid = (r_state == ST_OUT);
    end
    assign m_axis_tdata = {r_st[63:0], r_st[127:64]};
    assign m_axis_tlast = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mode   <= MODE_128;
            r_key    <= '0;
            r_iv     <= '0;
            r_chain  <= '0;
            r_kstart <= 1'b1;
            r_widx   <= '0;
            r_rnd    <= '0;
            r_wc     <= '0;
            r_apply  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_KEY_SIZE: begin
                        r_mode <= (i_cfg_data[1:0] == MODE_SAT) ? MODE_256 : i_cfg_data[1:0];
                        r_kstart <= 1'b1;
                    end
                    REG_KEY0: begin r_key[255:192] <= i_cfg_data; r_kstart <= 1'b1; end
                    REG_KEY1: begin r_key[191:128] <= i_cfg_data; r_kstart <= 1'b1; end
                    REG_KEY2: begin r_key[127:64]  <= i_cfg_data; r_kstart <= 1'b1; end
                    REG_KEY3: begin r_key[63:0]    <= i_cfg_data; r_kstart <= 1'b1; end
                    REG_IV_HI: begin r_iv[127:64] <= i_cfg_data; r_chain[127:64] <= i_cfg_data; end
                    REG_IV_LO: begin r_iv[63:0]   <= i_cfg_data; r_chain[63:0]   <= i_cfg_data; end
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (r_kstart && !i_cfg_we) begin
                        r_kstart <= 1'b0;
                        r_widx <= '0;
                        r_kc <= 3'd0;
                        r_rcon <= 8'h01;
                        for (int k = 0; k < 8; k++) r_w[k] <= r_key[255 - 32 * k -: 32];
                    end else if (!r_kstart && s_axis_tvalid && !i_cfg_we) begin
                        r_st <= {s_axis_tdata[63:0], s_axis_tdata[127:64]}
                                ^ (s_axis_tuser ? r_iv : r_chain);
                        r_last <= s_axis_tlast;
                        r_rnd <= '0;
                        r_wc <= '0;
                        r_apply <= 1'b0;
                    end
                end
                ST_KEY: begin
                    r_widx <= r_widx + 6'd1;
                    if (r_widx >= {2'b00, nk}) begin
                        for (int k = 0; k < 7; k++)
                            if (k + 1 < nk) r_w[k] <= r_w[k+1];
                        r_w[nk[2:0] - 3'd1] <= new_word;
                        if (r_kc == 3'd0) r_rcon <= xtime(r_rcon);
                        r_kc <= (r_kc == nk[2:0] - 3'd1 || (nk == 4'd8 && r_kc == 3'd7))
                                ? 3'd0 : r_kc + 3'd1;
                    end
                end
                ST_RUN: begin
                    // gather the four words of the round key, one per cycle
                    if (!r_apply) begin
                        r_wc <= r_wc + 2'd1;
                        if (r_wc == 2'd3) r_apply <= 1'b1;
                    end
                    if (r_apply || r_wc != 2'd0)
                        r_rk <= {r_rk[63:0], ram_rd};
                    if (r_apply) begin
                        // r_rk holds the first three words; the last word comes straight from ram_rd
                        if (r_rnd == 4'd0) r_st <= r_st ^ {r_rk, ram_rd};
                        else r_st <= enc_round(r_st, r_rnd == nr) ^ {r_rk, ram_rd};
                        r_rnd <= r_rnd + 4'd1;
                        r_apply <= 1'b0;
                        r_wc <= '0;
                    end
                end
                ST_OUT: if (m_axis_tready) r_chain <= r_st;
                default: ;
            endcase
        end
    end
endmodule

@@ hdl/aes_cbc_checker.sv @@
// Port-level checker for aes_cbc_encrypt_unit, bound to the top level.
// Depends on nothing but the top level's ports.
module aes_cbc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         i_cfg_we
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while result pending");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken during a block");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !s_axis_tready)
        else $error("request taken during config write");
endmodule

bind aes_cbc_encrypt_unit aes_cbc_checker u_chk (.*);
